@@ rtl/lcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared sizes, request codes, controller state and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lcs_pkg;

    // Store size and derived widths
    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int CH_W    = 8;

    // Request codes carried by req_type
    localparam logic REQ_FIRST  = 1'b0;
    localparam logic REQ_SECOND = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_DONE
    } state_t;

    // Commands from the controller
    typedef struct packed {
        logic take;    // input beat accepted this cycle
        logic scan;    // row scan in progress
        logic finish;  // load result and clear the job
    } cmd_t;

    // Status towards the controller
    typedef struct packed {
        logic second_full;  // second string already at store size
        logic row_done;     // every cell of the row has been written
        logic last_seen;    // latched last mark of the current second byte
        logic out_free;     // output register can take a result
    } sts_t;

endpackage

@@ rtl/lcs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_ctrl
// Controller: accepts beats while idle, scans one row per second-string byte
// within store size, hands the result to the output register on the last byte.
// ----------------------------------------------------------------------------
module lcs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          req_type,
    input  logic          last,
    input  lcs_pkg::sts_t sts,
    output lcs_pkg::cmd_t cmd,
    output logic          in_stall
);
    import lcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (req_type == REQ_SECOND))
                begin
                    if (sts.second_full)
                    begin
                        state_next = last ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ROW;
                    end
                end
            end
            S_ROW:
            begin
                if (sts.row_done)
                begin
                    state_next = sts.last_seen ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall   = 1'b1;
        cmd.take   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
            end
            S_ROW:
            begin
                cmd.scan = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/lcs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_datapath
// First-string store, run-length row memory, one-cell-per-cycle update of
// the row with best tracking, and the output register.
// ----------------------------------------------------------------------------
module lcs_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lcs_pkg::cmd_t            cmd,
    output lcs_pkg::sts_t            sts,
    input  logic                     req_type,
    input  logic [lcs_pkg::CH_W-1:0] ch,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [lcs_pkg::CNT_W-1:0] match_len,
    output logic [lcs_pkg::CNT_W-1:0] end_in_first,
    output logic [lcs_pkg::CNT_W-1:0] end_in_second,
    output logic [lcs_pkg::IDX_W-1:0] start_in_first,
    output logic                     overflowed
);
    import lcs_pkg::*;

    // Memories
    logic [CH_W-1:0]  store_mem [MAX_LEN];
    logic [CNT_W-1:0] row_mem   [MAX_LEN];

    // Job state
    logic [CNT_W-1:0] first_len_reg,   first_len_next;
    logic [CNT_W-1:0] second_pos_reg,  second_pos_next;
    logic [CNT_W-1:0] best_len_reg,    best_len_next;
    logic [CNT_W-1:0] best_first_reg,  best_first_next;
    logic [CNT_W-1:0] best_second_reg, best_second_next;
    logic             overflow_reg,    overflow_next;
    logic             last_reg,        last_next;
    logic             row_zero_reg,    row_zero_next;

    // Scan pipeline
    logic [CH_W-1:0]  ch_reg,        ch_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             pend_vld_reg,  pend_vld_next;
    logic [IDX_W-1:0] pend_idx_reg,  pend_idx_next;
    logic [CNT_W-1:0] prev_old_reg,  prev_old_next;
    logic [CH_W-1:0]  store_q_reg;
    logic [CNT_W-1:0] row_q_reg;

    // Output register
    logic             out_valid_reg,  out_valid_next;
    logic [CNT_W-1:0] out_len_reg,    out_len_next;
    logic [CNT_W-1:0] out_first_reg,  out_first_next;
    logic [CNT_W-1:0] out_second_reg, out_second_next;
    logic [IDX_W-1:0] out_start_reg,  out_start_next;
    logic             out_ovf_reg,    out_ovf_next;

    // Memory control
    logic             store_we;
    logic [IDX_W-1:0] store_waddr;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] cell_new;
    logic [CNT_W-1:0] cell_old;
    logic [CNT_W-1:0] cell_end;
    logic             issue_more;
    logic             better;

    assign rd_addr    = issue_cnt_reg[IDX_W-1:0];
    assign issue_more = issue_cnt_reg < first_len_reg;

    // Cell update: grow on a match over the old diagonal, else drop to zero
    assign cell_old = row_zero_reg ? '0 : row_q_reg;
    assign cell_new = (store_q_reg == ch_reg) ? (prev_old_reg + CNT_W'(1)) : '0;
    assign cell_end = CNT_W'(pend_idx_reg) + CNT_W'(1);
    assign better   = (cell_new != '0) &&
                      ((cell_new > best_len_reg) ||
                       ((cell_new == best_len_reg) && (cell_end < best_first_reg)));

    // Status
    assign sts.second_full = second_pos_reg >= CNT_W'(MAX_LEN);
    assign sts.row_done    = !issue_more && !pend_vld_reg;
    assign sts.last_seen   = last_reg;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    // Next values
    always_comb
    begin
        first_len_next   = first_len_reg;
        second_pos_next  = second_pos_reg;
        best_len_next    = best_len_reg;
        best_first_next  = best_first_reg;
        best_second_next = best_second_reg;
        overflow_next    = overflow_reg;
        last_next        = last_reg;
        row_zero_next    = row_zero_reg;
        ch_next          = ch_reg;
        issue_cnt_next   = issue_cnt_reg;
        pend_vld_next    = 1'b0;
        pend_idx_next    = pend_idx_reg;
        prev_old_next    = prev_old_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_len_next     = out_len_reg;
        out_first_next   = out_first_reg;
        out_second_next  = out_second_reg;
        out_start_next   = out_start_reg;
        out_ovf_next     = out_ovf_reg;
        store_we         = 1'b0;
        store_waddr      = first_len_reg[IDX_W-1:0];

        // Take an input beat
        if (cmd.take)
        begin
            if (req_type == REQ_FIRST)
            begin
                if (second_pos_reg == '0)
                begin
                    if (first_len_reg < CNT_W'(MAX_LEN))
                    begin
                        store_we       = 1'b1;
                        first_len_next = first_len_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
            end
            else
            begin
                last_next = last;
                if (sts.second_full)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    second_pos_next = second_pos_reg + CNT_W'(1);
                    row_zero_next   = second_pos_reg == '0;
                    ch_next         = ch;
                    issue_cnt_next  = '0;
                    prev_old_next   = '0;
                end
            end
        end

        // Advance the read side of the scan
        if (cmd.scan && issue_more)
        begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
            pend_idx_next  = rd_addr;
            pend_vld_next  = 1'b1;
        end

        // Retire one cell and track the best
        if (pend_vld_reg)
        begin
            prev_old_next = cell_old;
            if (better)
            begin
                best_len_next    = cell_new;
                best_first_next  = cell_end;
                best_second_next = second_pos_reg;
            end
        end

        // Load the result and clear the job
        if (cmd.finish)
        begin
            out_valid_next   = 1'b1;
            out_len_next     = best_len_reg;
            out_first_next   = best_first_reg;
            out_second_next  = best_second_reg;
            out_start_next   = (best_len_reg != '0) ?
                               IDX_W'(best_first_reg - best_len_reg) : '0;
            out_ovf_next     = overflow_reg;
            first_len_next   = '0;
            second_pos_next  = '0;
            best_len_next    = '0;
            best_first_next  = '0;
            best_second_next = '0;
            overflow_next    = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg   <= '0;
            second_pos_reg  <= '0;
            best_len_reg    <= '0;
            best_first_reg  <= '0;
            best_second_reg <= '0;
            overflow_reg    <= 1'b0;
            last_reg        <= 1'b0;
            row_zero_reg    <= 1'b0;
            issue_cnt_reg   <= '0;
            pend_vld_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            first_len_reg   <= first_len_next;
            second_pos_reg  <= second_pos_next;
            best_len_reg    <= best_len_next;
            best_first_reg  <= best_first_next;
            best_second_reg <= best_second_next;
            overflow_reg    <= overflow_next;
            last_reg        <= last_next;
            row_zero_reg    <= row_zero_next;
            issue_cnt_reg   <= issue_cnt_next;
            pend_vld_reg    <= pend_vld_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ch_reg         <= ch_next;
        pend_idx_reg   <= pend_idx_next;
        prev_old_reg   <= prev_old_next;
        out_len_reg    <= out_len_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
        out_start_reg  <= out_start_next;
        out_ovf_reg    <= out_ovf_next;
    end

    // First-string store: write on a kept byte, registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= ch;
        end
        store_q_reg <= store_mem[rd_addr];
    end

    // Run-length row: write the retired cell, registered read
    always_ff @(posedge clk)
    begin
        if (pend_vld_reg)
        begin
            row_mem[pend_idx_reg] <= cell_new;
        end
        row_q_reg <= row_mem[rd_addr];
    end

    assign out_valid      = out_valid_reg;
    assign match_len      = out_len_reg;
    assign end_in_first   = out_first_reg;
    assign end_in_second  = out_second_reg;
    assign start_in_first = out_start_reg;
    assign overflowed     = out_ovf_reg;

    // Checks
    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (CNT_W'(pend_idx_reg) < first_len_reg))
        else $error("retiring cell beyond first string");

    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        best_len_reg <= best_first_reg)
        else $error("best length exceeds its end position");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (out_valid_reg && (first_len_reg == '0) && (best_len_reg == '0)))
        else $error("result not loaded or job not cleared");

    a_lengths_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= CNT_W'(MAX_LEN)) && (second_pos_reg <= CNT_W'(MAX_LEN)))
        else $error("string length beyond store size");

endmodule

@@ rtl/longest_common_substring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_common_substring
// Timing: a first-string beat is taken while idle; a kept second-string beat
// holds off new beats while the row memory is scanned one cell per cycle.
// After the last byte's scan, the done state loads the output register.
// Throughput: one beat at a time; a waiting result blocks new beats only once
// the next result is ready.
// Reset: asynchronous, clears all control state; memories are not cleared.
// ----------------------------------------------------------------------------
// Longest common substring top level
// Joins the controller and the datapath.
// ----------------------------------------------------------------------------
module longest_common_substring (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic [lcs_pkg::CH_W-1:0]  ch,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [lcs_pkg::CNT_W-1:0] match_len,
    output logic [lcs_pkg::CNT_W-1:0] end_in_first,
    output logic [lcs_pkg::CNT_W-1:0] end_in_second,
    output logic [lcs_pkg::IDX_W-1:0] start_in_first,
    output logic                      overflowed
);
    import lcs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller
    lcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .last     (last),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Datapath
    lcs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .ch             (ch),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_len      (match_len),
        .end_in_first   (end_in_first),
        .end_in_second  (end_in_second),
        .start_in_first (start_in_first),
        .overflowed     (overflowed)
    );

endmodule
